// File: rtl/tbbp_pkg.sv
// Package for the two-bit branch predictor: table geometry, counter
// encoding and the counter update rule.
// No dependencies.
package tbbp_pkg;

	localparam int MAX_INDEX_BITS = 12;
	localparam int TABLE_DEPTH    = 1 << MAX_INDEX_BITS;
	localparam int CFG_W          = 4;
	localparam int PADDR_W        = 3;
	localparam int ADDR_W         = 32;
	localparam int S_TDATA_W      = 40;
	localparam int M_TDATA_W      = 8;

	typedef logic [MAX_INDEX_BITS-1:0] tbl_idx_t;

	// Counter encoding
	typedef enum logic [1:0] {
		CNT_SN = 2'd0,
		CNT_WN = 2'd1,
		CNT_WT = 2'd2,
		CNT_ST = 2'd3
	} cnt_t;

	// Register indexes
	localparam logic REG_INDEX_BITS = 1'b0;

	localparam logic [CFG_W-1:0] INDEX_BITS_RESET = CFG_W'(MAX_INDEX_BITS);

	// Update rule: weak states jump to the strong state of the outcome
	function automatic cnt_t next_cnt(input cnt_t cur, input logic taken);
		cnt_t nxt;
		case (cur)
			CNT_ST: nxt = taken ? CNT_ST : CNT_WT;
			CNT_WT: nxt = taken ? CNT_ST : CNT_SN;
			CNT_WN: nxt = taken ? CNT_ST : CNT_SN;
			CNT_SN: nxt = taken ? CNT_WN : CNT_SN;
			default: nxt = CNT_SN;
		endcase
		return nxt;
	endfunction

endpackage

// File: rtl/two_bit_branch_predictor.sv
// Two-bit branch predictor: 4096-entry counter table in a simple dual-port
// style array, one read and one write per cycle, with write forwarding.
// Depends on tbbp_pkg.
//
// An accepted input beat passes the stage 1 register, then the result register.
// Throughput: one beat per cycle unless stalled; the table read-modify-write
// spans the read register and the write-back, with the last write forwarded.
// Reset: after arst_n is released a clearing pass writes strong taken into
// all 4096 entries, one per cycle; s_axis_tready stays low until the pass
// has finished. Configuration writes are taken at any time.
module two_bit_branch_predictor (
	input  logic                              clk,
	input  logic                              arst_n,
	// input: [31:0] branch_address, [32] actual_taken, [39:33] zero
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [tbbp_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	// output: [0] predicted_taken, [7:1] zero
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [tbbp_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tbbp_pkg::PADDR_W-1:0]      paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import tbbp_pkg::*;

	logic [CFG_W-1:0]          index_bits_q;
	logic                      clr_active_q;
	tbl_idx_t                  clr_idx_q;
	logic [1:0]                mem [TABLE_DEPTH];

	logic                      vld_s1;
	tbl_idx_t                  idx_s1;
	logic                      taken_s1;
	logic [1:0]                rd_s1;

	logic                      wr_vld_q;
	tbl_idx_t                  wr_idx_q;
	cnt_t                      wr_cnt_q;

	logic                      out_vld_q;
	logic                      out_pred_q;

	logic                      in_acc;
	logic                      adv_s1;
	logic                      cfg_wr;
	logic [CFG_W-1:0]          nb_sat;
	tbl_idx_t                  idx_mask;
	tbl_idx_t                  idx_in;
	cnt_t                      cur_cnt;
	cnt_t                      upd_cnt;
	logic                      mem_we;
	tbl_idx_t                  mem_wa;
	cnt_t                      mem_wd;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_INDEX_BITS) ? {{(32-CFG_W){1'b0}}, index_bits_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q <= INDEX_BITS_RESET;
		end else if (cfg_wr && paddr[2] == REG_INDEX_BITS) begin
			index_bits_q <= pwdata[CFG_W-1:0];
		end
	end

	// Index from the low address bits, width saturated to the table size
	assign nb_sat = (index_bits_q > CFG_W'(MAX_INDEX_BITS)) ? CFG_W'(MAX_INDEX_BITS)
		: index_bits_q;

	always_comb begin
		for (int i = 0; i < MAX_INDEX_BITS; i++) begin
			idx_mask[i] = (CFG_W'(i) < nb_sat);
		end
	end

	assign idx_in = s_axis_tdata[MAX_INDEX_BITS-1:0] & idx_mask;

	// Handshake
	assign adv_s1        = vld_s1 && (!out_vld_q || m_axis_tready);
	assign s_axis_tready = !clr_active_q && (!vld_s1 || adv_s1);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// Clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_idx_q    <= '0;
		end else if (clr_active_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == {MAX_INDEX_BITS{1'b1}}) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	// Stage 1: item registered while the table entry is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_s1   <= idx_in;
			taken_s1 <= s_axis_tdata[ADDR_W];
		end
	end

	// Counter from the table, or from the last write when it hit the same entry
	assign cur_cnt = (wr_vld_q && wr_idx_q == idx_s1) ? wr_cnt_q : cnt_t'(rd_s1);
	assign upd_cnt = next_cnt(cur_cnt, taken_s1);

	// Table write port: clearing pass or write-back
	assign mem_we = clr_active_q || adv_s1;
	assign mem_wa = clr_active_q ? clr_idx_q : idx_s1;
	assign mem_wd = clr_active_q ? CNT_ST : upd_cnt;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (in_acc) begin
			rd_s1 <= mem[idx_in];
		end
	end

	// Last write-back, for forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q <= 1'b0;
		end else if (adv_s1) begin
			wr_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			wr_idx_q <= idx_s1;
			wr_cnt_q <= upd_cnt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_pred_q <= (cur_cnt == CNT_ST) || (cur_cnt == CNT_WT);
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(M_TDATA_W-1){1'b0}}, out_pred_q};

endmodule

// File: rtl/tbbp_checker.sv
// Port-level checks for the two-bit branch predictor, bound to the top level.
// Depends on tbbp_pkg.
module tbbp_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	input  logic                              s_axis_tready,
	input  logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	input  logic [tbbp_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tbbp_pkg::PADDR_W-1:0]      paddr,
	input  logic [31:0]                       pwdata,
	input  logic [31:0]                       prdata
);
	import tbbp_pkg::*;

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// Table clearing keeps the input closed right after reset
	a_clr_closed: assert property (@(posedge clk)
		$rose(arst_n) |-> !s_axis_tready)
		else $error("input open during table clear");

	// A new result must trace back to an accepted input beat
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without a matching input beat");

	// Index width register reads back what was written
	a_cfg_read: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr == '0) ##1 (paddr == '0)
		|-> prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0]))
		else $error("index_bits readback mismatch");

endmodule

bind two_bit_branch_predictor tbbp_checker u_tbbp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.psel          (psel),
	.penable       (penable),
	.pwrite        (pwrite),
	.paddr         (paddr),
	.pwdata        (pwdata),
	.prdata        (prdata)
);
